[rtl/bpa_pkg.sv]
// Shared types and helpers for the buddy page allocator.
// No dependencies; imported by the allocator unit and its testbench.
package bpa_pkg;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_BAD   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_IN_LEAF,
    S_IN_RL,
    S_IN_RR,
    S_IN_W,
    S_AL_ROOT,
    S_AL_ROOTD,
    S_DN_RL,
    S_DN_RR,
    S_DN_DEC,
    S_AL_MARK,
    S_FR_RD,
    S_FR_CHK,
    S_FX_RL,
    S_FX_RR,
    S_FX_W,
    S_RESP
  } state_t;

  function automatic logic [5:0] clog2_32(input logic [31:0] x);
    logic [5:0] o;
    o = 6'd0;
    for (int j = 0; j < 32; j++) begin
      if ((33'd1 << j) < {1'b0, x}) o = 6'(j + 1);
    end
    return o;
  endfunction

endpackage

[rtl/bpa_node_ram.sv]
// Node level memory: one write port, one read port, registered read data.
// Depends on nothing outside this file.
module bpa_node_ram #(
  parameter int DEPTH = 65535,
  parameter int AW    = 16,
  parameter int DW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/buddy_page_allocator_unit.sv]
// Buddy page allocator over a complete binary tree held in one node-level
// memory (2^(MAX_ORDER+1)-1 entries, one read and one write per cycle). One
// word is processed at a time. Alloc reads the root, then descends level by
// level to the granted block (read left child, read right child, decide) and
// rebuilds each ancestor going back up (read both children, write). Free
// climbs from the leaf to the used node (read, check per node), then rebuilds
// each ancestor the same way. Both read the two children of each node through
// the single read port. Init writes one leaf per cycle, then rebuilds each
// internal node by reading both children and writing it. Depends on bpa_pkg,
// bpa_node_ram.
module buddy_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int MAX_ORDER = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_pages,
  input  logic [14:0] in_page_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [14:0] out_block_offset,
  output logic [15:0] out_free_pages
);

  localparam int IDX_W = MAX_ORDER + 1;
  localparam int DEPTH = (1 << (MAX_ORDER + 1)) - 1;
  localparam int LVL_W = $clog2(MAX_ORDER + 1) + 1;
  localparam int TO_W  = $clog2(MAX_ORDER + 1);
  localparam int CNT_W = MAX_ORDER + 1;

  typedef logic signed [LVL_W-1:0] lvl_t;

  state_t              state_r, state_nxt;
  logic [15:0]         page_count_r;
  logic [TO_W-1:0]     tree_order_r, tree_order_nxt;
  logic [CNT_W-1:0]    usable_r, usable_nxt;
  logic [CNT_W-1:0]    free_r, free_nxt;
  logic                init_r, init_nxt;
  logic [4:0]          need_r, need_nxt;
  logic [14:0]         off_r, off_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    first_r, first_nxt;
  logic [CNT_W-1:0]    k_r, k_nxt;
  logic [TO_W-1:0]     d_r, d_nxt;
  logic [TO_W-1:0]     ord_r, ord_nxt;
  lvl_t                v_r, v_nxt;
  lvl_t                lv_r, lv_nxt;
  status_t             res_stat_r, res_stat_nxt;
  logic [14:0]         res_off_r, res_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [14:0]         out_off_r, out_off_nxt;
  logic [15:0]         out_free_r, out_free_nxt;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  lvl_t                mem_wdata, mem_rdata;

  logic [IDX_W-1:0]    base_to, child_l, child_r, parent;
  logic signed [7:0]   need_s, rd_s, lv_s, v_s;
  logic                fr_ok;
  logic [31:0]         pc_ext;
  logic [IDX_W-1:0]    off_calc;
  lvl_t                comb_val;

  function automatic lvl_t combine(input lvl_t l, input lvl_t r, input logic [TO_W-1:0] co);
    logic signed [7:0] ce;
    logic [7:0]        t;
    ce = $signed(8'(co));
    t  = 8'(co) + 8'd1;
    if (8'(l) == ce && 8'(r) == ce) return LVL_W'(t);
    return ($signed(l) > $signed(r)) ? l : r;
  endfunction

  bpa_node_ram #(
    .DEPTH(DEPTH),
    .AW   (IDX_W),
    .DW   (LVL_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign base_to  = (IDX_W'(1) << tree_order_r) - IDX_W'(1);
  assign child_l  = {idx_r[IDX_W-2:0], 1'b1};
  assign child_r  = child_l + IDX_W'(1);
  assign parent   = (idx_r - IDX_W'(1)) >> 1;
  assign need_s   = $signed({3'b000, need_r});
  assign rd_s     = 8'(mem_rdata);
  assign lv_s     = 8'(lv_r);
  assign v_s      = 8'(v_r);
  assign off_calc = (idx_r + IDX_W'(1) - (IDX_W'(1) << d_r)) << (tree_order_r - d_r);
  assign comb_val = combine(lv_r, mem_rdata, (state_r == S_IN_W) ? d_r : ord_r);
  assign fr_ok    = (rd_s == -8'sd1) &&
                    ((32'(off_r) & ((32'd1 << d_r) - 32'd1)) == 32'd0) &&
                    (need_r == 5'(d_r)) &&
                    ((32'(off_r) + (32'd1 << d_r)) <= 32'(usable_r));

  always_comb begin
    pc_ext = {16'd0, page_count_r};
    if (pc_ext == 32'd0) pc_ext = 32'd1;
    if (pc_ext > (32'd1 << MAX_ORDER)) pc_ext = 32'd1 << MAX_ORDER;
  end

  always_comb begin
    state_nxt      = state_r;
    tree_order_nxt = tree_order_r;
    usable_nxt     = usable_r;
    free_nxt       = free_r;
    init_nxt       = init_r;
    need_nxt       = need_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    k_nxt          = k_r;
    d_nxt          = d_r;
    ord_nxt        = ord_r;
    v_nxt          = v_r;
    lv_nxt         = lv_r;
    res_stat_nxt   = res_stat_r;
    res_off_nxt    = res_off_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_free_nxt   = out_free_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          need_nxt     = 5'(clog2_32(32'(in_pages)));
          off_nxt      = in_page_offset;
          res_off_nxt  = 15'd0;
          res_stat_nxt = STAT_NOFIT;
          case (kind_t'(in_kind))
            KIND_INIT: begin
              tree_order_nxt = TO_W'(clog2_32(pc_ext));
              usable_nxt     = CNT_W'(pc_ext);
              free_nxt       = CNT_W'(pc_ext);
              init_nxt       = 1'b1;
              k_nxt          = '0;
              res_stat_nxt   = STAT_OK;
              state_nxt      = S_IN_LEAF;
            end
            KIND_ALLOC: begin
              state_nxt = init_r ? S_AL_ROOT : S_RESP;
            end
            KIND_FREE: begin
              if (!init_r) begin
                state_nxt = S_RESP;
              end else if ((32'(in_page_offset) >> tree_order_r) != 32'd0) begin
                res_stat_nxt = STAT_BAD;
                state_nxt    = S_RESP;
              end else begin
                idx_nxt   = IDX_W'(in_page_offset) + base_to;
                d_nxt     = '0;
                state_nxt = S_FR_RD;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_IN_LEAF: begin
        k_nxt = k_r + CNT_W'(1);
        if (k_r == CNT_W'(base_to)) begin
          if (tree_order_r == '0) begin
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = base_to - IDX_W'(1);
            first_nxt = (IDX_W'(1) << (tree_order_r - TO_W'(1))) - IDX_W'(1);
            d_nxt     = '0;
            state_nxt = S_IN_RL;
          end
        end
      end
      S_IN_RL: state_nxt = S_IN_RR;
      S_IN_RR: begin
        lv_nxt    = mem_rdata;
        state_nxt = S_IN_W;
      end
      S_IN_W: begin
        if (idx_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          if (idx_r == first_r) begin
            d_nxt     = d_r + TO_W'(1);
            first_nxt = first_r >> 1;
          end
          idx_nxt   = idx_r - IDX_W'(1);
          state_nxt = S_IN_RL;
        end
      end
      S_AL_ROOT: state_nxt = S_AL_ROOTD;
      S_AL_ROOTD: begin
        if (rd_s < need_s) begin
          state_nxt = S_RESP;
        end else begin
          v_nxt     = mem_rdata;
          idx_nxt   = '0;
          d_nxt     = '0;
          state_nxt = (tree_order_r == '0) ? S_AL_MARK : S_DN_RL;
        end
      end
      S_DN_RL: state_nxt = S_DN_RR;
      S_DN_RR: begin
        lv_nxt    = mem_rdata;
        state_nxt = S_DN_DEC;
      end
      S_DN_DEC: begin
        state_nxt = S_AL_MARK;
        if (v_s == need_s) begin
          if (lv_s == need_s) begin
            idx_nxt = child_l;
            v_nxt   = lv_r;
            d_nxt   = d_r + TO_W'(1);
          end else if (rd_s == need_s) begin
            idx_nxt = child_r;
            v_nxt   = mem_rdata;
            d_nxt   = d_r + TO_W'(1);
          end
        end else if (v_s > need_s) begin
          if (rd_s >= need_s && (rd_s < lv_s || lv_s < need_s)) begin
            idx_nxt = child_r;
            v_nxt   = mem_rdata;
          end else begin
            idx_nxt = child_l;
            v_nxt   = lv_r;
          end
          d_nxt = d_r + TO_W'(1);
        end
        if (d_nxt != d_r && (d_r + TO_W'(1)) != tree_order_r) state_nxt = S_DN_RL;
      end
      S_AL_MARK: begin
        res_stat_nxt = STAT_OK;
        res_off_nxt  = 15'(off_calc);
        free_nxt     = free_r - (CNT_W'(1) << need_r);
        ord_nxt      = tree_order_r - d_r;
        idx_nxt      = parent;
        state_nxt    = (idx_r == '0) ? S_RESP : S_FX_RL;
      end
      S_FR_RD: state_nxt = S_FR_CHK;
      S_FR_CHK: begin
        if (rd_s != -8'sd1 && idx_r != '0) begin
          idx_nxt   = parent;
          d_nxt     = d_r + TO_W'(1);
          state_nxt = S_FR_RD;
        end else if (!fr_ok) begin
          res_stat_nxt = STAT_BAD;
          state_nxt    = S_RESP;
        end else begin
          res_stat_nxt = STAT_OK;
          free_nxt     = free_r + (CNT_W'(1) << d_r);
          ord_nxt      = d_r;
          idx_nxt      = parent;
          state_nxt    = (idx_r == '0) ? S_RESP : S_FX_RL;
        end
      end
      S_FX_RL: state_nxt = S_FX_RR;
      S_FX_RR: begin
        lv_nxt    = mem_rdata;
        state_nxt = S_FX_W;
      end
      S_FX_W: begin
        ord_nxt   = ord_r + TO_W'(1);
        idx_nxt   = parent;
        state_nxt = (idx_r == '0) ? S_RESP : S_FX_RL;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_stat_r;
          out_off_nxt    = res_off_r;
          out_free_nxt   = 16'(free_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = comb_val;
    mem_raddr = child_l;
    case (state_r)
      S_IN_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = base_to + IDX_W'(k_r);
        mem_wdata = (k_r < usable_r) ? lvl_t'(0) : lvl_t'(-1);
      end
      S_IN_RR, S_DN_RR, S_FX_RR: mem_raddr = child_r;
      S_IN_W, S_FX_W: mem_we = 1'b1;
      S_AL_ROOT: mem_raddr = '0;
      S_AL_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = lvl_t'(-1);
      end
      S_FR_RD: mem_raddr = idx_r;
      S_FR_CHK: begin
        mem_we    = fr_ok && !(rd_s != -8'sd1 && idx_r != '0);
        mem_wdata = LVL_W'(d_r);
      end
      default: mem_raddr = child_l;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      page_count_r <= 16'h8000;
      tree_order_r <= '0;
      usable_r     <= '0;
      free_r       <= '0;
      init_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wr_en) page_count_r <= cfg_wr_data;
      tree_order_r <= tree_order_nxt;
      usable_r     <= usable_nxt;
      free_r       <= free_nxt;
      init_r       <= init_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    k_r          <= k_nxt;
    d_r          <= d_nxt;
    ord_r        <= ord_nxt;
    v_r          <= v_nxt;
    lv_r         <= lv_nxt;
    res_stat_r   <= res_stat_nxt;
    res_off_r    <= res_off_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_block_offset = out_off_r;
  assign out_free_pages   = out_free_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted but engine not busy");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> (free_r <= usable_r))
    else $error("free page count exceeds managed pages");

  a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tree_order_r) <= MAX_ORDER)
    else $error("tree order out of range");

  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && !(out_valid_r && out_stall)) |=> (out_valid_r && !in_stall))
    else $error("result not presented on return to idle");

endmodule

[test/buddy_page_allocator_unit_test.sv]
// Self-checking testbench for buddy_page_allocator_unit: a directed table then random
// init/alloc/free traffic; each result word is checked against its typed table row or an in-bench tree model.
// Depends on bpa_pkg and the buddy_page_allocator_unit RTL.
module buddy_page_allocator_unit_test
  import bpa_pkg::*;
();

  localparam int MAXORD = 15;
  localparam int NODES = (1 << (MAXORD + 1)) - 1;
  localparam int LIMIT = 10000000;

  typedef struct packed {
    status_t     st;
    logic [14:0] blk;
    logic [15:0] fp;
  } alloc_word_t;

  typedef struct {
    bit          wr_cfg;
    logic [15:0] cfg_val;
    kind_t       kind;
    logic [15:0] pages;
    logic [14:0] off;
    bit          typed;
    alloc_word_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [15:0] in_pages;
  logic [14:0] in_page_offset;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [14:0] out_block_offset;
  logic [15:0] out_free_pages;

  buddy_page_allocator_unit #(.MAX_ORDER(MAXORD)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_pages(in_pages), .in_page_offset(in_page_offset),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_offset(out_block_offset), .out_free_pages(out_free_pages)
  );

  logic signed [4:0] lvl [NODES];
  int          t_order;
  int          f_count;
  bit          ready;
  int          usable;
  int          pg_reg;

  alloc_word_t pending_q[$];
  int          live_off[$];
  int          live_pg[$];
  int          errors;
  int          cycles;
  int          press_req;
  int          press_seen;
  int          press_cnt;
  logic        press_on;
  int          hold_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clog(int x);
    int o;
    o = 0;
    while (o < 31 && (1 << o) < x) o++;
    return o;
  endfunction

  function automatic int merge_lv(int l, int r, int co);
    if (l == co && r == co) return co + 1;
    return (l > r) ? l : r;
  endfunction

  function automatic void climb(int idx, int ord);
    while (idx > 0) begin
      idx = (idx - 1) / 2;
      lvl[idx] = 5'(merge_lv(lvl[2 * idx + 1], lvl[2 * idx + 2], ord));
      ord++;
    end
  endfunction

  function automatic alloc_word_t predict(kind_t k, int pages, int off);
    alloc_word_t w;
    int n, base, need, idx, d, v, lv, rv, i;
    w.st = STAT_NOFIT;
    w.blk = '0;
    if (k == KIND_INIT) begin
      n = pg_reg;
      if (n == 0) n = 1;
      if (n > (1 << MAXORD)) n = 1 << MAXORD;
      t_order = clog(n);
      base = (1 << t_order) - 1;
      for (int j = 0; j < (1 << t_order); j++) lvl[base + j] = (j < n) ? 5'sd0 : -5'sd1;
      for (int dd = t_order - 1; dd >= 0; dd--)
        for (int j = (1 << dd) - 1; j <= (2 << dd) - 2; j++)
          lvl[j] = 5'(merge_lv(lvl[2 * j + 1], lvl[2 * j + 2], t_order - dd - 1));
      usable = n;
      f_count = n;
      ready = 1;
      w.st = STAT_OK;
    end else if (k == KIND_ALLOC) begin
      need = clog(pages == 0 ? 1 : pages);
      if (ready && int'(lvl[0]) >= need) begin
        idx = 0;
        d = 0;
        while (d < t_order) begin
          v = lvl[idx];
          lv = lvl[2 * idx + 1];
          rv = lvl[2 * idx + 2];
          if (v < need) break;
          if (v == need) begin
            if (lv == need) idx = 2 * idx + 1;
            else if (rv == need) idx = 2 * idx + 2;
            else break;
          end else if (rv >= need && (rv < lv || lv < need)) begin
            idx = 2 * idx + 2;
          end else begin
            idx = 2 * idx + 1;
          end
          d++;
        end
        w.blk = 15'((idx + 1 - (1 << d)) << (t_order - d));
        f_count -= 1 << need;
        lvl[idx] = -5'sd1;
        climb(idx, t_order - d);
        w.st = STAT_OK;
      end
    end else if (k == KIND_FREE) begin
      if (ready) begin
        w.st = STAT_BAD;
        need = clog(pages == 0 ? 1 : pages);
        if (off < (1 << t_order)) begin
          idx = off + (1 << t_order) - 1;
          i = 0;
          while (idx > 0 && lvl[idx] != -5'sd1) begin
            idx = (idx - 1) / 2;
            i++;
          end
          if (lvl[idx] == -5'sd1 && (off & ((1 << i) - 1)) == 0 && need == i &&
              off + (1 << i) <= usable) begin
            lvl[idx] = 5'(i);
            climb(idx, i);
            f_count += 1 << i;
            w.st = STAT_OK;
          end
        end
      end
    end
    w.fp = 16'(f_count);
    return w;
  endfunction

  task automatic send(kind_t k, logic [15:0] pages, logic [14:0] off, bit typed,
                      alloc_word_t typed_res, output alloc_word_t got);
    int gap, r;
    in_valid <= 1'b1;
    in_kind <= k;
    in_pages <= pages;
    in_page_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = predict(k, pages, off);
    pending_q.push_back(typed ? typed_res : got);
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_pages(logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pg_reg = v;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (press_cnt > 0) begin
      press_cnt <= press_cnt - 1;
      press_on <= 1'b1;
    end else if (press_req != press_seen) begin
      press_seen <= press_req;
      press_cnt <= 400;
    end else begin
      press_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    alloc_word_t e;
    int r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: st=%0d blk=%0d fp=%0d",
                                   out_status, out_block_offset, out_free_pages);
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.st || out_block_offset !== e.blk || out_free_pages !== e.fp) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d blk=%0d fp=%0d got st=%0d blk=%0d fp=%0d",
                     e.st, e.blk, e.fp, out_status, out_block_offset, out_free_pages);
        end
      end
    end
    if (hold_n > 0) begin
      hold_n <= hold_n - 1;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) hold_n <= $urandom_range(15, 60);
      else if (r < 15) hold_n <= $urandom_range(1, 3);
      out_stall <= press_on;
    end
  end

  dir_row_t dir_tab[] = '{
    '{0, 0, KIND_ALLOC, 16'd1, 15'd0, 1, '{STAT_NOFIT, 15'd0, 16'd0}},
    '{0, 0, KIND_FREE, 16'd1, 15'd0, 1, '{STAT_NOFIT, 15'd0, 16'd0}},
    '{0, 0, KIND_NONE, 16'hFFFF, 15'h7FFF, 1, '{STAT_NOFIT, 15'd0, 16'd0}},
    '{0, 0, KIND_INIT, 16'd0, 15'd0, 1, '{STAT_OK, 15'd0, 16'd32768}},
    '{0, 0, KIND_ALLOC, 16'd0, 15'd0, 0, '0},
    '{0, 0, KIND_ALLOC, 16'd32768, 15'd0, 0, '0},
    '{0, 0, KIND_FREE, 16'd1, 15'd0, 0, '0},
    '{0, 0, KIND_ALLOC, 16'd32768, 15'd0, 1, '{STAT_OK, 15'd0, 16'd0}},
    '{0, 0, KIND_ALLOC, 16'd1, 15'd0, 1, '{STAT_NOFIT, 15'd0, 16'd0}},
    '{0, 0, KIND_FREE, 16'd32768, 15'd0, 1, '{STAT_OK, 15'd0, 16'd32768}},
    '{0, 0, KIND_ALLOC, 16'hFFFF, 15'd0, 1, '{STAT_NOFIT, 15'd0, 16'd32768}},
    '{0, 0, KIND_FREE, 16'd1, 15'h7FFF, 1, '{STAT_BAD, 15'd0, 16'd32768}},
    '{1, 0, KIND_INIT, 16'd0, 15'd0, 1, '{STAT_OK, 15'd0, 16'd1}},
    '{0, 0, KIND_ALLOC, 16'd2, 15'd0, 1, '{STAT_NOFIT, 15'd0, 16'd1}},
    '{0, 0, KIND_ALLOC, 16'd1, 15'd0, 1, '{STAT_OK, 15'd0, 16'd0}},
    '{0, 0, KIND_FREE, 16'd0, 15'd0, 1, '{STAT_OK, 15'd0, 16'd1}},
    '{1, 5, KIND_INIT, 16'd0, 15'd0, 1, '{STAT_OK, 15'd0, 16'd5}},
    '{0, 0, KIND_ALLOC, 16'd3, 15'd0, 0, '0},
    '{0, 0, KIND_ALLOC, 16'd1, 15'd0, 0, '0},
    '{0, 0, KIND_FREE, 16'd2, 15'd0, 0, '0},
    '{0, 0, KIND_FREE, 16'd4, 15'd2, 0, '0},
    '{0, 0, KIND_FREE, 16'd1, 15'd6, 0, '0},
    '{0, 0, KIND_FREE, 16'd1, 15'd8, 0, '0},
    '{0, 0, KIND_INIT, 16'd0, 15'd0, 0, '0},
    '{1, 16'd40000, KIND_INIT, 16'd0, 15'd0, 1, '{STAT_OK, 15'd0, 16'd32768}}
  };

  initial begin
    alloc_word_t got;
    int r, n, pick, sent;
    kind_t k;
    logic [15:0] pg;
    errors = 0;
    cycles = 0;
    press_req = 0;
    press_seen = 0;
    press_cnt = 0;
    press_on = 1'b0;
    hold_n = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_kind = KIND_INIT;
    in_pages = '0;
    in_page_offset = '0;
    out_stall = 1'b0;
    t_order = 0;
    f_count = 0;
    ready = 0;
    usable = 0;
    pg_reg = 32768;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_cfg) write_pages(dir_tab[i].cfg_val);
      send(dir_tab[i].kind, dir_tab[i].pages, dir_tab[i].off, dir_tab[i].typed,
           dir_tab[i].res, got);
    end

    sent = 0;
    for (int ph = 0; sent < 1700; ph++) begin
      r = $urandom_range(0, 99);
      n = (ph == 3) ? 32768 : (r < 70) ? $urandom_range(1, 64) :
          (r < 95) ? $urandom_range(65, 1024) : $urandom_range(1025, 4096);
      write_pages(16'(n));
      live_off.delete();
      live_pg.delete();
      send(KIND_INIT, 16'($urandom), 15'($urandom), 0, '0, got);
      if (ph == 1) press_req++;
      for (int j = 0; j < 110; j++) begin
        r = $urandom_range(0, 99);
        pg = 16'(1 << $urandom_range(0, clog(n)));
        if (r < 45) pg = 16'($urandom_range(0, pg));
        if (r < 50 || (r < 80 && live_off.size() == 0)) begin
          send(KIND_ALLOC, pg, 15'($urandom), 0, '0, got);
          if (got.st == STAT_OK) begin
            live_off.push_back(got.blk);
            live_pg.push_back(1 << clog(pg == 0 ? 1 : pg));
          end
        end else if (r < 80) begin
          pick = $urandom_range(0, live_off.size() - 1);
          send(KIND_FREE, 16'(live_pg[pick]), 15'(live_off[pick]), 0, '0, got);
          live_off.delete(pick);
          live_pg.delete(pick);
        end else if (r < 98) begin
          k = kind_t'($urandom_range(1, 3));
          send(k, 16'($urandom), 15'($urandom), 0, '0, got);
          if (k == KIND_ALLOC && got.st == STAT_OK) begin
            live_off.push_back(got.blk);
            live_pg.push_back(1 << clog(in_pages));
          end
        end else begin
          send(KIND_INIT, 16'($urandom), 15'($urandom), 0, '0, got);
          live_off.delete();
          live_pg.delete();
        end
        sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bpa_pkg.sv
rtl/bpa_node_ram.sv
rtl/buddy_page_allocator_unit.sv
test/buddy_page_allocator_unit_test.sv
